@@ rtl/dma_channel_register_controller_assert.svh @@
// Assertion macros of the DMA channel register controller top level.
`ifndef DMA_CHANNEL_REGISTER_CONTROLLER_ASSERT_SVH
`define DMA_CHANNEL_REGISTER_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset.
`define DCRC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("dcrc assertion failed");

// Checked on every clock edge, reset included.
`define DCRC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("dcrc assertion failed");

`else

`define DCRC_ASSERT(lbl, prop)
`define DCRC_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

@@ rtl/dcrc_pkg.sv @@
// Shared constants and types of the DMA channel register controller.
`timescale 1ns / 1ps

package dcrc_pkg;

    localparam int NUM_CHANNELS = 7;
    localparam int MEM_DEPTH    = NUM_CHANNELS * 4;
    localparam int MEM_AW       = $clog2(MEM_DEPTH);

    localparam logic [3:0] CHAN_LIMIT = 4'(NUM_CHANNELS);

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    localparam logic [6:0] OFF_PRIORITY  = 7'h70;
    localparam logic [6:0] OFF_INTERRUPT = 7'h74;

    localparam logic [1:0] REG_ADDR   = 2'd0;
    localparam logic [1:0] REG_COUNT  = 2'd1;
    localparam logic [1:0] REG_CTRL   = 2'd2;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam logic [2:0] CHAN_DREQ  = 3'd2;
    localparam logic [2:0] CHAN_DISC  = 3'd3;
    localparam logic [2:0] CHAN_TABLE = 3'd6;

    localparam logic [2:0] KIND_IMMEDIATE   = 3'd0;
    localparam logic [2:0] KIND_LINKED_LIST = 3'd1;
    localparam logic [2:0] KIND_BLOCK_OUT   = 3'd2;
    localparam logic [2:0] KIND_READBACK    = 3'd3;
    localparam logic [2:0] KIND_DISC_IN     = 3'd4;
    localparam logic [2:0] KIND_TABLE_CLEAR = 3'd5;

    localparam logic [1:0] SYNC_LINKED_LIST = 2'd2;

    localparam logic [31:0] FLAG_MASK = 32'h7F00_0000;
    localparam logic [31:0] CH6_KEEP  = 32'h5100_0000;
    localparam logic [31:0] CH6_FORCE = 32'h0000_0002;
    localparam logic [31:0] ADDR_MASK = 32'h00FF_FFFF;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

    // Request from the access logic to the channel register memory.
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [MEM_AW-1:0] addr;
        logic [31:0]       wr_data;
    } t_mem_req;

    // Result of one transaction before the memory read data is merged in.
    typedef struct packed {
        logic [31:0] rd_fix;
        logic        use_mem;
        logic        started;
        logic [2:0]  chan;
        logic [2:0]  kind;
        logic        raise;
        logic        master;
    } t_result;

endpackage

@@ rtl/dma_channel_register_controller.sv @@
// Top level of the DMA channel register controller: handshake and result pipeline.
`timescale 1ns / 1ps

// Register file of a seven-channel DMA controller seen from the processor bus. One register
// access is taken per cycle, back to back, unless the result pipeline is held by i_ready. Each
// access returns one result, through the registered read of the channel register memory and
// then the output register. The memory holds the address, block count and control words; the
// priority and interrupt words sit in flip-flops. A control write that meets the start rule
// finishes its transfer in the same access and reports the engine kind. Two results can wait
// in the pipeline, so a new access is still taken while the last result is not yet collected.

`include "dma_channel_register_controller_assert.svh"

module dma_channel_register_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [6:0]  i_offset,
    input  logic [31:0] i_write_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_read_data,
    output logic        o_transfer_started,
    output logic [2:0]  o_started_channel,
    output logic [2:0]  o_transfer_kind,
    output logic        o_irq_raise,
    output logic        o_irq_master
);

    dcrc_pkg::t_mem_req mem_req;
    dcrc_pkg::t_result  acc_res;
    dcrc_pkg::t_result  r_s1;
    logic               r_v1;
    logic               r_v2;
    logic [31:0]        mem_rd_data;
    logic               acc;
    logic               s1_adv;

    logic [31:0] r_read_data;
    logic        r_started;
    logic [2:0]  r_chan;
    logic [2:0]  r_kind;
    logic        r_raise;
    logic        r_master;

    assign s1_adv  = r_v1 && (!r_v2 || i_ready);
    assign o_ready = !r_v1 || s1_adv;
    assign acc     = i_valid && o_ready;

    dcrc_access u_access (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (acc),
        .i_mode       (i_mode),
        .i_offset     (i_offset),
        .i_write_data (i_write_data),
        .o_req        (mem_req),
        .o_res        (acc_res)
    );

    dcrc_pkg::t_mem_req mem_req_q;

    // Nothing touches the memory unless the transaction is taken.
    always_comb begin
        mem_req_q       = mem_req;
        mem_req_q.wr_en = mem_req.wr_en && acc;
        mem_req_q.rd_en = mem_req.rd_en && acc;
    end

    dcrc_chan_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req_q),
        .o_rd_data (mem_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (acc) begin
                r_v1 <= 1'b1;
            end else if (s1_adv) begin
                r_v1 <= 1'b0;
            end
            if (s1_adv) begin
                r_v2 <= 1'b1;
            end else if (i_ready) begin
                r_v2 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1 <= acc_res;
        end
        if (s1_adv) begin
            r_read_data <= r_s1.use_mem ? mem_rd_data : r_s1.rd_fix;
            r_started   <= r_s1.started;
            r_chan      <= r_s1.chan;
            r_kind      <= r_s1.kind;
            r_raise     <= r_s1.raise;
            r_master    <= r_s1.master;
        end
    end

    assign o_valid            = r_v2;
    assign o_read_data        = r_read_data;
    assign o_transfer_started = r_started;
    assign o_started_channel  = r_chan;
    assign o_transfer_kind    = r_kind;
    assign o_irq_raise        = r_raise;
    assign o_irq_master       = r_master;

    `DCRC_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !r_v1 && !r_v2)
    `DCRC_ASSERT(a_full_stalls, r_v1 && r_v2 && !i_ready |-> !o_ready)
    `DCRC_ASSERT(a_start_no_data, o_valid && o_transfer_started |-> o_read_data == 32'd0)
    `DCRC_ASSERT(a_start_chan_ok,
        o_valid && o_transfer_started |-> 4'(o_started_channel) < dcrc_pkg::CHAN_LIMIT)

endmodule

@@ rtl/dcrc_chan_mem.sv @@
// Channel register memory: address, block count and control words of all channels.
`timescale 1ns / 1ps

module dcrc_chan_mem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dcrc_pkg::t_mem_req i_req,
    output logic [31:0]        o_rd_data
);

    logic [31:0] r_mem [dcrc_pkg::MEM_DEPTH];
    logic [31:0] r_rd_data;
    logic [dcrc_pkg::MEM_DEPTH-1:0] r_valid;
    logic        r_rd_valid;
    logic        r_rd_dflt;
    logic [4:0]  addr5;

    assign addr5 = 5'(i_req.addr);

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    // An entry that was never written reads as its reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_rd_dflt  <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.addr];
                r_rd_dflt  <= (addr5 == {dcrc_pkg::CHAN_TABLE, dcrc_pkg::REG_CTRL});
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data :
                       (r_rd_dflt ? dcrc_pkg::CH6_FORCE : 32'd0);

endmodule

@@ rtl/dcrc_access.sv @@
// Access decode, global registers and the start and finish logic of a transfer.
`timescale 1ns / 1ps

module dcrc_access (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_acc,
    input  logic               i_mode,
    input  logic [6:0]         i_offset,
    input  logic [31:0]        i_write_data,
    output dcrc_pkg::t_mem_req o_req,
    output dcrc_pkg::t_result  o_res
);

    logic [31:0] r_prio;
    logic [31:0] r_iw;
    logic [31:0] n_prio;
    logic [31:0] n_iw;

    logic [2:0]  chan;
    logic [1:0]  rsel;
    logic        chan_ok;
    logic        is_ch_reg;
    logic [31:0] iw_a;
    logic [31:0] iw_b;
    logic [31:0] ctl;
    logic        start;
    logic        cond;

    function automatic logic master_cond(input logic [31:0] iw);
        master_cond = iw[15] || (iw[23] && ((iw[22:16] & iw[30:24]) != 7'd0));
    endfunction

    function automatic logic [2:0] kind_of(input logic [2:0] c, input logic [31:0] ctl_w);
        logic [2:0] k;
        k = dcrc_pkg::KIND_IMMEDIATE;
        if (c == dcrc_pkg::CHAN_DREQ) begin
            if (ctl_w[10:9] == dcrc_pkg::SYNC_LINKED_LIST) begin
                k = dcrc_pkg::KIND_LINKED_LIST;
            end else if (ctl_w[0]) begin
                k = dcrc_pkg::KIND_READBACK;
            end else begin
                k = dcrc_pkg::KIND_BLOCK_OUT;
            end
        end else if (c == dcrc_pkg::CHAN_DISC) begin
            k = dcrc_pkg::KIND_DISC_IN;
        end else if (c == dcrc_pkg::CHAN_TABLE) begin
            k = dcrc_pkg::KIND_TABLE_CLEAR;
        end
        return k;
    endfunction

    always_comb begin
        chan      = i_offset[6:4];
        rsel      = i_offset[3:2];
        chan_ok   = (i_offset < dcrc_pkg::OFF_PRIORITY) && ({1'b0, chan} < dcrc_pkg::CHAN_LIMIT);
        is_ch_reg = chan_ok && (rsel != dcrc_pkg::REG_UNUSED);

        n_prio = r_prio;
        n_iw   = r_iw;
        iw_a   = r_iw & ~(i_write_data & dcrc_pkg::FLAG_MASK);
        iw_b   = (iw_a & dcrc_pkg::FLAG_MASK) | (i_write_data & ~dcrc_pkg::FLAG_MASK);
        ctl    = (chan == dcrc_pkg::CHAN_TABLE) ?
                 ((i_write_data & dcrc_pkg::CH6_KEEP) | dcrc_pkg::CH6_FORCE) : i_write_data;
        // The sync, busy and trigger bits come from the written word itself.
        start  = i_write_data[24]
                 && ((i_write_data[10:9] != 2'd0) || i_write_data[28]
                     || ((chan == dcrc_pkg::CHAN_DREQ) && ctl[0]))
                 && r_prio[{chan, 2'b11}];
        cond   = 1'b0;

        o_req         = '0;
        o_req.addr    = {chan, rsel};
        o_res         = '0;

        if (i_mode == dcrc_pkg::MODE_READ) begin
            if (i_offset == dcrc_pkg::OFF_PRIORITY) begin
                o_res.rd_fix = r_prio;
            end else if (i_offset == dcrc_pkg::OFF_INTERRUPT) begin
                o_res.rd_fix = r_iw;
            end else if (is_ch_reg) begin
                o_res.use_mem = 1'b1;
                o_req.rd_en   = 1'b1;
            end else begin
                o_res.rd_fix = dcrc_pkg::ALL_ONES;
            end
        end else if (i_offset == dcrc_pkg::OFF_PRIORITY) begin
            n_prio = i_write_data;
        end else if (i_offset == dcrc_pkg::OFF_INTERRUPT) begin
            cond        = master_cond(iw_b);
            n_iw        = {cond, iw_b[30:0]};
            o_res.raise = cond;
        end else if (is_ch_reg) begin
            o_req.wr_en = 1'b1;
            unique case (rsel)
                dcrc_pkg::REG_ADDR: begin
                    o_req.wr_data = i_write_data & dcrc_pkg::ADDR_MASK;
                end
                dcrc_pkg::REG_COUNT: begin
                    o_req.wr_data = i_write_data;
                end
                dcrc_pkg::REG_CTRL: begin
                    o_req.wr_data = ctl;
                    if (start) begin
                        // The transfer finishes at once: busy and trigger clear.
                        o_res.kind    = kind_of(chan, ctl);
                        o_res.started = 1'b1;
                        o_res.chan    = chan;
                        o_req.wr_data[24] = 1'b0;
                        o_req.wr_data[28] = 1'b0;
                        if (chan == dcrc_pkg::CHAN_TABLE) begin
                            o_req.wr_data[30] = 1'b0;
                        end
                        iw_b = r_iw;
                        if (r_iw[{2'b10, chan}]) begin
                            iw_b[{2'b11, chan}] = 1'b1;
                        end
                        cond        = master_cond(iw_b);
                        n_iw        = {cond, iw_b[30:0]};
                        o_res.raise = cond;
                    end
                end
                default: begin
                    o_req.wr_en = 1'b0;
                end
            endcase
        end

        o_res.master = n_iw[31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio <= '0;
            r_iw   <= '0;
        end else if (i_acc) begin
            r_prio <= n_prio;
            r_iw   <= n_iw;
        end
    end

endmodule
